// File: design/bfa_pkg.sv
// shared types, constants and the bit-search function of the bitmap allocator
package bfa_pkg;

    localparam int WORD_W     = 32;
    localparam int BIT_W      = 5;
    localparam int INDEX_W    = 8;
    localparam int INDEX_SPAN = 256;
    localparam int MAX_WORDS  = INDEX_SPAN / WORD_W;
    localparam int STATUS_W   = 2;
    localparam int TDATA_W    = 16;

    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_RANGE = 2'd2;

    typedef struct packed {
        logic             found;
        logic [BIT_W-1:0] pos;
    } ffz_t;

    function automatic ffz_t find_first_zero(input logic [WORD_W-1:0] word);
        ffz_t r;
        r.found = 1'b0;
        r.pos   = '0;
        for (int i = WORD_W - 1; i >= 0; i--)
        begin
            if (!word[i])
            begin
                r.found = 1'b1;
                r.pos   = BIT_W'(i);
            end
        end
        return r;
    endfunction

endpackage

// File: design/bfa_ram.sv
// generic single-write, single-read ram with registered read data
module bfa_ram #(
    parameter int WIDTH  = 32,
    parameter int DEPTH  = 8,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem_q [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_q[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem_q[rd_addr];
        end
    end

endmodule

// File: design/bitmap_first_free_allocator.sv
// first-fit bitmap allocator top level: sequencer, bitmap ram and result register
// allocate scans words from word 0 until one holds a zero bit or the last is read
// free reads one word; the bitmap ram delivers one 32-bit word per cycle to one bit search
// a command is accepted only in idle; an unread result delays the finish of the next one
// reset: per-word valid bits clear at once so every entry reads free, no clearing pass
module bitmap_first_free_allocator #(
    parameter int NUM_WORDS = 8
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // free_index[7:0]
    input  logic [0:0]  s_tuser,   // command[0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata    // alloc_index[7:0], status[9:8], zero[15:10]
);

    localparam int USED_WORDS = (NUM_WORDS < bfa_pkg::MAX_WORDS) ? NUM_WORDS
                                                                 : bfa_pkg::MAX_WORDS;
    localparam int ADDR_W = (USED_WORDS > 1) ? $clog2(USED_WORDS) : 1;
    localparam logic [bfa_pkg::INDEX_W:0] LIMIT =
        (bfa_pkg::INDEX_W + 1)'(USED_WORDS * bfa_pkg::WORD_W);
    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(USED_WORDS - 1);

    localparam logic [0:0] S_IDLE = 1'b0;
    localparam logic [0:0] S_EVAL = 1'b1;

    logic [0:0]                     state_reg, state_next;
    logic [ADDR_W-1:0]              addr_reg, addr_next;
    logic                           cmd_reg, cmd_next;
    logic [bfa_pkg::INDEX_W-1:0]    idx_reg, idx_next;
    logic                           range_reg, range_next;
    logic [USED_WORDS-1:0]          word_valid_reg;
    logic                           out_valid_reg, out_valid_next;
    logic [bfa_pkg::INDEX_W-1:0]    out_index_reg, out_index_next;
    logic [bfa_pkg::STATUS_W-1:0]   out_status_reg, out_status_next;

    logic                           accept;
    logic                           out_free;
    logic                           rd_en;
    logic [ADDR_W-1:0]              rd_addr;
    logic [bfa_pkg::WORD_W-1:0]     rd_data;
    logic                           wr_en;
    logic [bfa_pkg::WORD_W-1:0]     wr_data;
    logic [bfa_pkg::WORD_W-1:0]     word;
    logic [bfa_pkg::WORD_W-1:0]     bit_mask;
    logic [bfa_pkg::BIT_W-1:0]      bit_pos;
    bfa_pkg::ffz_t                  ffz;

    bfa_ram #(
        .WIDTH  (bfa_pkg::WORD_W),
        .DEPTH  (USED_WORDS),
        .ADDR_W (ADDR_W)
    ) u_bitmap (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (addr_reg),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign s_tready = (state_reg == S_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign out_free = !out_valid_reg || m_tready;

    assign word     = word_valid_reg[addr_reg] ? rd_data : '0;
    assign ffz      = bfa_pkg::find_first_zero(word);
    assign bit_pos  = (cmd_reg == bfa_pkg::CMD_FREE) ? idx_reg[bfa_pkg::BIT_W-1:0] : ffz.pos;
    assign bit_mask = bfa_pkg::WORD_W'(1) << bit_pos;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(bfa_pkg::TDATA_W - bfa_pkg::STATUS_W - bfa_pkg::INDEX_W){1'b0}},
                       out_status_reg, out_index_reg};

    always_comb
    begin
        state_next      = state_reg;
        addr_next       = addr_reg;
        cmd_next        = cmd_reg;
        idx_next        = idx_reg;
        range_next      = range_reg;
        out_valid_next  = out_valid_reg && !m_tready;
        out_index_next  = out_index_reg;
        out_status_next = out_status_reg;
        rd_en           = 1'b0;
        rd_addr         = addr_reg;
        wr_en           = 1'b0;
        wr_data         = word;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    cmd_next   = s_tuser[0];
                    idx_next   = s_tdata;
                    range_next = (s_tuser[0] == bfa_pkg::CMD_FREE) &&
                                 ({1'b0, s_tdata} >= LIMIT);
                    rd_en      = 1'b1;
                    rd_addr    = (s_tuser[0] == bfa_pkg::CMD_FREE) ?
                                 s_tdata[bfa_pkg::BIT_W +: ADDR_W] : '0;
                    addr_next  = rd_addr;
                    state_next = S_EVAL;
                end
            end
            S_EVAL:
            begin
                if ((cmd_reg == bfa_pkg::CMD_ALLOC) && !ffz.found && (addr_reg != LAST_ADDR))
                begin
                    rd_en     = 1'b1;
                    rd_addr   = ADDR_W'(addr_reg + 1'b1);
                    addr_next = rd_addr;
                end
                else if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_index_next  = '0;
                    out_status_next = bfa_pkg::ST_OK;
                    state_next      = S_IDLE;
                    if (range_reg)
                    begin
                        out_status_next = bfa_pkg::ST_RANGE;
                    end
                    else if (cmd_reg == bfa_pkg::CMD_FREE)
                    begin
                        wr_en   = 1'b1;
                        wr_data = word & ~bit_mask;
                    end
                    else if (ffz.found)
                    begin
                        wr_en          = 1'b1;
                        wr_data        = word | bit_mask;
                        out_index_next = bfa_pkg::INDEX_W'({addr_reg, ffz.pos});
                    end
                    else
                    begin
                        out_status_next = bfa_pkg::ST_FULL;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            out_valid_reg  <= 1'b0;
            word_valid_reg <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            if (wr_en)
            begin
                word_valid_reg[addr_reg] <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        addr_reg       <= addr_next;
        cmd_reg        <= cmd_next;
        idx_reg        <= idx_next;
        range_reg      <= range_next;
        out_index_reg  <= out_index_next;
        out_status_reg <= out_status_next;
    end

    a_result_after_eval: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == S_EVAL))
        else $error("result loaded outside evaluation");

    a_index_zero_on_error: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && (out_status_reg != bfa_pkg::ST_OK) |-> (out_index_reg == '0))
        else $error("nonzero index on error status");

    a_index_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> ({1'b0, out_index_reg} < LIMIT))
        else $error("granted index beyond bitmap");

    a_write_only_on_finish: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> (state_reg == S_EVAL) && out_free && !range_reg)
        else $error("bitmap written outside a finishing step");

endmodule
